[src/gregorian_date_add_days_unit_macros.svh]
// ----------------------------------------------------------------------------
// Gregorian date add days unit - assertion macros
// Concurrent checks clocked by clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_DAYS_UNIT_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GDAU_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gregorian_date_add_days_unit: check failed");
// next-cycle implication
`define GDAU_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gregorian_date_add_days_unit: check failed");
`else
`define GDAU_ASSERT_IMPL(name, ante, cons)
`define GDAU_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[src/gdau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date add days - package
// Field widths, division constants and calendar helper functions.
// ----------------------------------------------------------------------------
package gdau_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int OFS_W    = 16;
	localparam int IN_DW    = 40;
	localparam int OUT_DW   = 24;

	// year estimate: floor((400*g + 591) / 146097), biased to stay non-negative
	localparam int YR_DIV    = 146097;
	localparam int YR_BIAS   = 100;
	localparam int YR_SHIFT  = 49;
	localparam int A_OFS     = 591 + YR_BIAS * YR_DIV;
	localparam logic [63:0] YR_RECIP_W =
		((64'd1 << YR_SHIFT) + 64'(YR_DIV) - 64'd1) / 64'(YR_DIV);
	localparam logic [31:0] YR_RECIP = YR_RECIP_W[31:0];

	// month index: floor(n / 3060) = floor((n >> 2) / 765)
	localparam int MON_DIV   = 765;
	localparam int MON_SHIFT = 24;
	localparam logic [14:0] MON_RECIP =
		15'(((1 << MON_SHIFT) + MON_DIV - 1) / MON_DIV);

	localparam logic [3:0] MI_JAN = 4'd10;

	// month 1..12 to March-based index 0..11, (month + 9) mod 12
	function automatic logic [3:0] mar_index(input logic [3:0] month);
		logic [3:0] r;
		case (month)
			4'd0:  r = 4'd9;
			4'd1:  r = 4'd10;
			4'd2:  r = 4'd11;
			4'd3:  r = 4'd0;
			4'd4:  r = 4'd1;
			4'd5:  r = 4'd2;
			4'd6:  r = 4'd3;
			4'd7:  r = 4'd4;
			4'd8:  r = 4'd5;
			4'd9:  r = 4'd6;
			4'd10: r = 4'd7;
			4'd11: r = 4'd8;
			4'd12: r = 4'd9;
			4'd13: r = 4'd10;
			4'd14: r = 4'd11;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// first day of March-based month, (mi * 306 + 5) / 10
	function automatic logic [8:0] month_start(input logic [3:0] mi);
		logic [8:0] r;
		case (mi)
			4'd0:  r = 9'd0;
			4'd1:  r = 9'd31;
			4'd2:  r = 9'd61;
			4'd3:  r = 9'd92;
			4'd4:  r = 9'd122;
			4'd5:  r = 9'd153;
			4'd6:  r = 9'd184;
			4'd7:  r = 9'd214;
			4'd8:  r = 9'd245;
			4'd9:  r = 9'd275;
			4'd10: r = 9'd306;
			4'd11: r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// floor(x / 100) for x below 25600
	function automatic logic [7:0] div100(input logic [14:0] x);
		logic [29:0] p;
		p = {15'b0, x} * 30'd20972;
		return p[28:21];
	endfunction

	// days before March-based year y; yb = y + 400, q = yb / 100
	function automatic logic signed [24:0] days_before(
		input logic signed [15:0] y,
		input logic [14:0]        yb,
		input logic [7:0]         q
	);
		logic signed [24:0] ye;
		ye = {{9{y[15]}}, y};
		return ye * 25'sd365 + $signed({12'b0, yb[14:2]}) - $signed({17'b0, q})
			+ $signed({19'b0, q[7:2]}) - 25'sd97;
	endfunction

endpackage

[src/gregorian_date_add_days_unit.sv]
// Path: an input is registered in stages s1 to s9; s9 drives the output.
// Throughput: one date per cycle while the output is not stalled; the
// nine-stage pipeline closes bubbles while the output is stalled.
// Reset: arst_n clears all stage valid bits at once; data registers keep
// their contents and are ignored until refilled.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date add days unit
// Converts a date to a March-based day number, adds a signed day offset and
// converts back with a year estimate and one-step correction.
// ----------------------------------------------------------------------------
`include "gregorian_date_add_days_unit_macros.svh"

module gregorian_date_add_days_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [13:0] year, [17:14] month, [22:18] day, [38:23] day_offset, [39] zero
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [13:0] result_year, [17:14] result_month, [22:18] result_day, [23] zero
	output logic [23:0] m_axis_tdata,
	// [0] out_of_range
	output logic        m_axis_tuser
);
	import gdau_pkg::*;

	logic [9:1] load;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	// stage payloads
	logic signed [15:0] y0_s1;
	logic [14:0]        yb_s1;
	logic [7:0]         q100_s1;
	logic [8:0]         mstart_s1;
	logic [DAY_W-1:0]   day_s1;
	logic signed [OFS_W-1:0] off_s1;

	logic signed [24:0] dby_s2;
	logic signed [17:0] dpart_s2;

	logic signed [24:0] g_s3;

	logic [31:0]        a_s4;
	logic signed [24:0] g_s4;

	logic signed [15:0] y_s5;
	logic signed [24:0] g_s5;

	logic signed [15:0] y_s6;
	logic [14:0]        yb_s6;
	logic [7:0]         q100_s6;
	logic signed [24:0] g_s6;

	logic [8:0]         yday_s7;
	logic signed [15:0] yr_s7;

	logic [3:0]         mi_s8;
	logic [8:0]         yday_s8;
	logic signed [15:0] yr_s8;

	logic [YEAR_W-1:0]  year_s9;
	logic [MONTH_W-1:0] month_s9;
	logic [DAY_W-1:0]   day_s9;
	logic               oor_s9;

	// each stage advances when empty or when the next one advances
	always_comb begin
		load[9] = !vld_s9 || m_axis_tready;
		load[8] = !vld_s8 || load[9];
		load[7] = !vld_s7 || load[8];
		load[6] = !vld_s6 || load[7];
		load[5] = !vld_s5 || load[6];
		load[4] = !vld_s4 || load[5];
		load[3] = !vld_s3 || load[4];
		load[2] = !vld_s2 || load[3];
		load[1] = !vld_s1 || load[2];
	end

	assign s_axis_tready = load[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (load[1]) vld_s1 <= s_axis_tvalid;
			if (load[2]) vld_s2 <= vld_s1;
			if (load[3]) vld_s3 <= vld_s2;
			if (load[4]) vld_s4 <= vld_s3;
			if (load[5]) vld_s5 <= vld_s4;
			if (load[6]) vld_s6 <= vld_s5;
			if (load[7]) vld_s7 <= vld_s6;
			if (load[8]) vld_s8 <= vld_s7;
			if (load[9]) vld_s9 <= vld_s8;
		end
	end

	// ---- stage 1: March-based year and month, year / 100
	logic [YEAR_W-1:0]  in_year;
	logic [MONTH_W-1:0] in_month;
	logic [3:0]         m1_c;
	logic               jf1_c;
	logic signed [15:0] y0_c;
	logic signed [15:0] yb1_sum;

	always_comb begin
		in_year  = s_axis_tdata[13:0];
		in_month = s_axis_tdata[17:14];
		m1_c     = mar_index(in_month);
		// January and February count with the previous year
		jf1_c    = (m1_c >= MI_JAN);
		y0_c     = $signed({2'b00, in_year}) - $signed({15'b0, jf1_c});
		yb1_sum  = y0_c + 16'sd400;
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			y0_s1     <= y0_c;
			yb_s1     <= yb1_sum[14:0];
			q100_s1   <= div100(yb1_sum[14:0]);
			mstart_s1 <= month_start(m1_c);
			day_s1    <= s_axis_tdata[22:18];
			off_s1    <= $signed(s_axis_tdata[38:23]);
		end
	end

	// ---- stage 2: days before the year, and the rest of the day number
	always_ff @(posedge clk) begin
		if (load[2]) begin
			dby_s2   <= days_before(y0_s1, yb_s1, q100_s1);
			dpart_s2 <= $signed({9'b0, mstart_s1}) + $signed({13'b0, day_s1})
				+ {{2{off_s1[15]}}, off_s1} - 18'sd1;
		end
	end

	// ---- stage 3: shifted day number
	always_ff @(posedge clk) begin
		if (load[3]) begin
			g_s3 <= dby_s2 + {{7{dpart_s2[17]}}, dpart_s2};
		end
	end

	// ---- stage 4: biased numerator of the year estimate
	logic signed [33:0] a4_c;

	always_comb begin
		a4_c = {{9{g_s3[24]}}, g_s3} * 34'sd400 + $signed(34'(A_OFS));
	end

	always_ff @(posedge clk) begin
		if (load[4]) begin
			a_s4 <= a4_c[31:0];
			g_s4 <= g_s3;
		end
	end

	// ---- stage 5: year estimate by reciprocal multiply
	logic [63:0] p5_c;

	always_comb begin
		p5_c = {32'b0, a_s4} * {32'b0, YR_RECIP};
	end

	always_ff @(posedge clk) begin
		if (load[5]) begin
			y_s5 <= $signed({1'b0, p5_c[63:YR_SHIFT]}) - $signed(16'(YR_BIAS));
			g_s5 <= g_s4;
		end
	end

	// ---- stage 6: estimate / 100
	logic signed [15:0] yb6_sum;

	always_comb begin
		yb6_sum = y_s5 + 16'sd400;
	end

	always_ff @(posedge clk) begin
		if (load[6]) begin
			y_s6    <= y_s5;
			yb_s6   <= yb6_sum[14:0];
			q100_s6 <= div100(yb6_sum[14:0]);
			g_s6    <= g_s5;
		end
	end

	// ---- stage 7: day of year, step back one year when the estimate is high
	logic signed [24:0] yd0_c;
	logic signed [24:0] ydc_c;
	logic signed [15:0] yr7_c;
	logic [14:0]        q100x_c;
	logic               c4_c;
	logic               c100_c;
	logic               c400_c;
	logic               leap_c;

	always_comb begin
		yd0_c   = g_s6 - days_before(y_s6, yb_s6, q100_s6);
		q100x_c = {7'b0, q100_s6} * 15'd100;
		c4_c    = (yb_s6[1:0] == 2'b00);
		c100_c  = (q100x_c == yb_s6);
		c400_c  = c100_c && (q100_s6[1:0] == 2'b00);
		// the year before ends with 29 February of year y when y is a leap year
		leap_c  = c4_c && (!c100_c || c400_c);
		if (yd0_c[24]) begin
			ydc_c = yd0_c + 25'sd365 + $signed({24'b0, leap_c});
			yr7_c = y_s6 - 16'sd1;
		end else begin
			ydc_c = yd0_c;
			yr7_c = y_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (load[7]) begin
			yday_s7 <= ydc_c[8:0];
			yr_s7   <= yr7_c;
		end
	end

	// ---- stage 8: month index, floor((100 * yday + 52) / 3060)
	logic [15:0] n8_c;
	logic [28:0] p8_c;

	always_comb begin
		n8_c = {7'b0, yday_s7} * 16'd100 + 16'd52;
		p8_c = {15'b0, n8_c[15:2]} * {14'b0, MON_RECIP};
	end

	always_ff @(posedge clk) begin
		if (load[8]) begin
			mi_s8   <= p8_c[27:24];
			yday_s8 <= yday_s7;
			yr_s8   <= yr_s7;
		end
	end

	// ---- stage 9: calendar fields and range check, output register
	logic signed [15:0] yr9_c;
	logic [8:0]         dd9_c;
	logic [3:0]         mo9_c;
	logic               oor9_c;

	always_comb begin
		yr9_c  = yr_s8 + $signed({15'b0, (mi_s8 >= MI_JAN)});
		dd9_c  = yday_s8 - month_start(mi_s8) + 9'd1;
		mo9_c  = (mi_s8 < MI_JAN) ? mi_s8 + 4'd3 : mi_s8 - 4'd9;
		oor9_c = (yr9_c < 16'sd1) || (yr9_c > 16'sd9999);
	end

	always_ff @(posedge clk) begin
		if (load[9]) begin
			year_s9  <= oor9_c ? '0 : yr9_c[13:0];
			month_s9 <= oor9_c ? '0 : mo9_c;
			day_s9   <= oor9_c ? '0 : dd9_c[4:0];
			oor_s9   <= oor9_c;
		end
	end

	assign m_axis_tvalid = vld_s9;
	assign m_axis_tdata  = {1'b0, day_s9, month_s9, year_s9};
	assign m_axis_tuser  = oor_s9;

	`GDAU_ASSERT_IMPL(a_flag_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 24'd0)
	`GDAU_ASSERT_IMPL(a_date_ok, m_axis_tvalid && !m_axis_tuser, year_s9 >= 14'd1 && year_s9 <= 14'd9999 && month_s9 >= 4'd1 && month_s9 <= 4'd12 && day_s9 >= 5'd1)
	`GDAU_ASSERT_IMPL(a_yday_max, vld_s7, yday_s7 <= 9'd365)
	`GDAU_ASSERT_IMPL(a_mi_max, vld_s8, mi_s8 <= 4'd11)
	`GDAU_ASSERT_NEXT(a_hold_s8, vld_s8 && !load[9], vld_s8 && $stable(mi_s8) && $stable(yday_s8))

endmodule
